// ===== rtl/log2_domain_cumulative_sum_macros.svh =====
// assertion macros shared by the cumulative log-sum rtl
`ifndef LOG2_DOMAIN_CUMULATIVE_SUM_MACROS_SVH
`define LOG2_DOMAIN_CUMULATIVE_SUM_MACROS_SVH

// same-cycle implication, held off while reset is low
`define L2DCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("l2dcs assertion failed");

// next-cycle implication, held off while reset is low
`define L2DCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("l2dcs assertion failed");

`endif

// ===== rtl/l2dcs_pkg.sv =====
// shared types, constants and table-building functions for the cumulative log-sum block
package l2dcs_pkg;

    localparam int DATA_W              = 32;
    localparam int ADDR_W              = 3;
    localparam int FRAC_BITS_DEF       = 16;
    localparam int CORR_TABLE_BITS_DEF = 10;
    localparam int TRUNC_LIMIT         = 32;
    localparam int ROOT_DEPTH          = 32;

    localparam logic signed [DATA_W-1:0] LOG_NEG_INF = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] LOG_MAX     = 32'sh7fff_ffff;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_UPPER = 2'd1;
    localparam logic [1:0] MODE_LOWER = 2'd2;

    localparam logic REG_MODE = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0]        x;
        logic signed [DATA_W-1:0] pick;
        logic                     need_log;
        logic                     term_inf;
        logic                     reset_sum;
        logic                     emit;
    } t_side;

    function automatic logic [63:0] f_isqrt(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] nn;
        r  = '0;
        b  = 64'h1 << 62;
        nn = n;
        for (int k = 0; k < 32; k++) begin
            if (b > nn) begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 0) begin
                if (nn >= r + b) begin
                    nn = nn - (r + b);
                    r  = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // log2 of v / 2^fin, truncated to frac_bits fraction bits
    function automatic longint f_log2_fix(input logic [63:0] v, input int fin,
                                          input int frac_bits);
        int          p;
        logic [63:0] m;
        longint      res;
        p = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                p = i;
            end
        end
        m   = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
        res = longint'(p - fin) * (longint'(1) << frac_bits);
        for (int i = 31; i >= 0; i--) begin
            if (i < frac_bits) begin
                m = (m * m) >> 30;
                if (m >= 64'h8000_0000) begin
                    m   = m >> 1;
                    res = res + (longint'(1) << i);
                end
            end
        end
        return res;
    endfunction

    // corr(idx * 32 / 2^ctb) = log2(1 + 2^-d), with 2^-d built from shifts and roots of two
    function automatic logic [DATA_W-1:0] f_corr_entry(input int idx, input int frac_bits,
                                                       input int ctb);
        int          fb;
        int          ip;
        logic [63:0] root;
        logic [63:0] y;
        longint      lv;
        fb   = ctb - 5;
        ip   = idx >> fb;
        root = 64'h1 << 31;
        y    = 64'h1 << 32;
        y    = y >> ((ip > 32) ? 32 : ip);
        for (int k = 1; k <= ROOT_DEPTH; k++) begin
            if (k <= fb) begin
                root = f_isqrt(root << 32);
                if (((idx >> (fb - k)) & 1) != 0) begin
                    y = (y * root) >> 32;
                end
            end
        end
        lv = f_log2_fix((64'h1 << 32) + y, 32, frac_bits);
        return lv[DATA_W-1:0];
    endfunction

endpackage

// ===== rtl/log2_domain_cumulative_sum.sv =====
// top level of the base-2 log-domain cumulative sum over curve points
// registered stages: input, x-step log2 normalise, one squaring per fraction bit, term, output
// throughput: one item per cycle while the skid slot is empty (o_stall is high otherwise)
// the running-sum log-add is combinational, ahead of the output register and skid slot
// reset (synchronous, active low) clears mode, sum, previous point and all pipeline valids

`include "log2_domain_cumulative_sum_macros.svh"

module log2_domain_cumulative_sum
    import l2dcs_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int CORR_TABLE_BITS = CORR_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [DATA_W-1:0]        i_x_pos,
    input  logic signed [DATA_W-1:0] i_log_y,
    input  logic                     i_curve_start,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DATA_W-1:0]        o_x_out,
    output logic signed [DATA_W-1:0] o_log_sum
);

    // configuration
    logic [1:0] r_mode;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_MODE) ? {30'd0, r_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PLAIN;
        end else if (w_cfg_wr && (paddr[2] == REG_MODE)) begin
            r_mode <= pwdata[1:0];
        end
    end

    // pipeline enable: everything moves while the skid slot is empty
    logic r_skid_valid;
    logic w_en;
    logic w_in_acc;

    assign w_en     = !r_skid_valid;
    assign o_stall  = r_skid_valid || !i_rst_n;
    assign w_in_acc = i_valid && !o_stall;

    // input stage: previous point and the term selection
    logic [DATA_W-1:0]        r_prev_x;
    logic signed [DATA_W-1:0] r_prev_log_y;
    logic                     r_have_prev;

    logic                     w_bound;
    logic                     w_first;
    logic signed [DATA_W-1:0] w_pick;
    t_side                    w_side;

    always_comb begin
        w_bound = (r_mode == MODE_UPPER) || (r_mode == MODE_LOWER);
        w_first = i_curve_start || !r_have_prev;
        case (r_mode)
            MODE_UPPER: w_pick = (i_log_y > r_prev_log_y) ? i_log_y : r_prev_log_y;
            MODE_LOWER: w_pick = (i_log_y < r_prev_log_y) ? i_log_y : r_prev_log_y;
            default:    w_pick = i_log_y;
        endcase
        w_side.x         = i_x_pos;
        w_side.pick      = w_pick;
        w_side.need_log  = w_bound;
        // first point of a bound curve only clears the sum
        w_side.term_inf  = w_bound
                         && (w_first || (i_x_pos <= r_prev_x) || (w_pick == LOG_NEG_INF));
        w_side.reset_sum = w_bound ? w_first : i_curve_start;
        w_side.emit      = !w_bound || !w_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x     <= '0;
            r_prev_log_y <= LOG_NEG_INF;
            r_have_prev  <= 1'b0;
        end else if (w_in_acc) begin
            r_prev_x     <= i_x_pos;
            r_prev_log_y <= i_log_y;
            r_have_prev  <= 1'b1;
        end
    end

    logic              r_s0_valid;
    t_side             r_s0_side;
    logic [DATA_W-1:0] r_s0_dx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_side <= w_side;
            r_s0_dx   <= i_x_pos - r_prev_x;
        end
    end

    // log2 of the x step
    logic                     w_l_valid;
    t_side                    w_l_side;
    logic signed [DATA_W-1:0] w_l_log;

    l2dcs_log2 #(
        .FRAC_BITS (FRAC_BITS)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s0_valid),
        .i_side  (r_s0_side),
        .i_dx    (r_s0_dx),
        .o_valid (w_l_valid),
        .o_side  (w_l_side),
        .o_log   (w_l_log)
    );

    // term stage
    logic signed [DATA_W:0]   w_t_wide;
    logic signed [DATA_W-1:0] w_t_clamp;
    logic signed [DATA_W-1:0] w_t_term;

    always_comb begin
        w_t_wide = (DATA_W+1)'(w_l_side.pick) + (DATA_W+1)'(w_l_log);
        if (w_t_wide > (DATA_W+1)'(LOG_MAX)) begin
            w_t_clamp = LOG_MAX;
        end else if (w_t_wide < (DATA_W+1)'(LOG_NEG_INF)) begin
            w_t_clamp = LOG_NEG_INF;
        end else begin
            w_t_clamp = w_t_wide[DATA_W-1:0];
        end
        if (w_l_side.term_inf) begin
            w_t_term = LOG_NEG_INF;
        end else if (w_l_side.need_log) begin
            w_t_term = w_t_clamp;
        end else begin
            w_t_term = w_l_side.pick;
        end
    end

    logic                     r_t_valid;
    t_side                    r_t_side;
    logic signed [DATA_W-1:0] r_t_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else if (w_en) begin
            r_t_valid <= w_l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_side <= w_l_side;
            r_t_term <= w_t_term;
        end
    end

    // running sum
    logic signed [DATA_W-1:0] r_acc;
    logic signed [DATA_W-1:0] w_base;
    logic signed [DATA_W-1:0] w_acc_new;
    logic                     w_fin_fire;

    assign w_fin_fire = r_t_valid && w_en;
    assign w_base     = r_t_side.reset_sum ? LOG_NEG_INF : r_acc;

    l2dcs_log_add #(
        .FRAC_BITS       (FRAC_BITS),
        .CORR_TABLE_BITS (CORR_TABLE_BITS)
    ) u_log_add (
        .i_a   (w_base),
        .i_b   (r_t_term),
        .o_sum (w_acc_new)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= LOG_NEG_INF;
        end else if (w_fin_fire) begin
            r_acc <= w_acc_new;
        end
    end

    // output register with one skid slot
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_x;
    logic signed [DATA_W-1:0] r_out_sum;
    logic [DATA_W-1:0]        r_skid_x;
    logic signed [DATA_W-1:0] r_skid_sum;

    logic w_out_take;
    logic w_res;
    logic w_load_out;
    logic w_load_skid;
    logic w_out_from_skid;
    logic n_out_valid;
    logic n_skid_valid;

    always_comb begin
        w_out_take      = r_out_valid && !i_stall;
        w_res           = w_fin_fire && r_t_side.emit;
        w_out_from_skid = r_skid_valid && w_out_take;
        w_load_out      = w_res && (!r_out_valid || w_out_take);
        w_load_skid     = w_res && r_out_valid && !w_out_take;
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        if (w_out_from_skid) begin
            n_skid_valid = 1'b0;
        end else if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (w_load_skid) begin
            n_skid_valid = 1'b1;
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out_x   <= r_skid_x;
            r_out_sum <= r_skid_sum;
        end else if (w_load_out) begin
            r_out_x   <= r_t_side.x;
            r_out_sum <= w_acc_new;
        end
        if (w_load_skid) begin
            r_skid_x   <= r_t_side.x;
            r_skid_sum <= w_acc_new;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_x_out   = r_out_x;
    assign o_log_sum = r_out_sum;

    `L2DCS_ASSERT_IMP(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `L2DCS_ASSERT_NXT(a_sum_cleared, i_clk, i_rst_n, w_fin_fire && r_t_side.reset_sum && (r_t_term == LOG_NEG_INF), r_acc == LOG_NEG_INF)
    `L2DCS_ASSERT_IMP(a_inf_only_from_inf, i_clk, i_rst_n, w_fin_fire, (w_acc_new == LOG_NEG_INF) == ((w_base == LOG_NEG_INF) && (r_t_term == LOG_NEG_INF)))

endmodule

// ===== rtl/l2dcs_log2.sv =====
// pipelined fixed-point log2 of the x step: a normalising stage, then one squaring per stage
`include "log2_domain_cumulative_sum_macros.svh"

module l2dcs_log2
    import l2dcs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_side                    i_side,
    input  logic [DATA_W-1:0]        i_dx,
    output logic                     o_valid,
    output t_side                    o_side,
    output logic signed [DATA_W-1:0] o_log
);

    localparam logic signed [DATA_W-1:0] FRAC_S = DATA_W'(FRAC_BITS);

    logic                 r_vld  [0:FRAC_BITS];
    t_side                r_side [0:FRAC_BITS];
    logic [30:0]          r_m    [0:FRAC_BITS];
    logic [4:0]           r_p    [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] r_fr   [0:FRAC_BITS];

    logic [4:0]        w_p;
    logic [DATA_W-1:0] w_norm;

    // leading one position and normalise to a q30 mantissa
    always_comb begin
        w_p = '0;
        for (int i = 0; i < DATA_W; i++) begin
            if (i_dx[i]) begin
                w_p = 5'(i);
            end
        end
        w_norm = i_dx << (5'd31 - w_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_m[0]    <= w_norm[31:1];
            r_p[0]    <= w_p;
            r_fr[0]   <= '0;
        end
    end

    for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_sq
        logic [61:0]          w_sq_full;
        logic [31:0]          w_sq;
        logic [30:0]          n_m;
        logic [FRAC_BITS-1:0] n_fr;

        always_comb begin
            w_sq_full = 62'(r_m[j-1]) * 62'(r_m[j-1]);
            w_sq      = w_sq_full[61:30];
            n_fr      = r_fr[j-1];
            // square at or above two: halve and emit a one bit
            n_fr[FRAC_BITS-j] = w_sq[31];
            n_m       = w_sq[31] ? w_sq[31:1] : w_sq[30:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= r_vld[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= r_side[j-1];
                r_m[j]    <= n_m;
                r_p[j]    <= r_p[j-1];
                r_fr[j]   <= n_fr;
            end
        end
    end

    logic signed [DATA_W-1:0] w_int;

    assign w_int   = $signed({27'd0, r_p[FRAC_BITS]}) - FRAC_S;
    assign o_valid = r_vld[FRAC_BITS];
    assign o_side  = r_side[FRAC_BITS];
    assign o_log   = (w_int <<< FRAC_BITS)
                   + $signed({{(DATA_W-FRAC_BITS){1'b0}}, r_fr[FRAC_BITS]});

    `L2DCS_ASSERT_IMP(a_norm_first, i_clk, i_rst_n, r_vld[0] && r_side[0].need_log && !r_side[0].term_inf, r_m[0][30])
    `L2DCS_ASSERT_IMP(a_norm_last, i_clk, i_rst_n, r_vld[FRAC_BITS] && r_side[FRAC_BITS].need_log && !r_side[FRAC_BITS].term_inf, r_m[FRAC_BITS][30])
    `L2DCS_ASSERT_IMP(a_log_floor, i_clk, i_rst_n, o_valid && o_side.need_log && !o_side.term_inf, o_log >= -(FRAC_S <<< FRAC_BITS))

endmodule

// ===== rtl/l2dcs_log_add.sv =====
// base-2 log-add with table correction: max(a,b) + log2(1 + 2^-|a-b|)
module l2dcs_log_add
    import l2dcs_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int CORR_TABLE_BITS = CORR_TABLE_BITS_DEF
) (
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output logic signed [DATA_W-1:0] o_sum
);

    localparam int CORR_SIZE  = (1 << CORR_TABLE_BITS) + 1;
    localparam int CORR_W     = FRAC_BITS + 1;
    localparam int IDX_W      = CORR_TABLE_BITS + 1;
    localparam int SH         = FRAC_BITS + 5 - CORR_TABLE_BITS;
    localparam int SH_R       = (SH >= 0) ? SH : 0;
    localparam int SH_L       = (SH < 0) ? -SH : 0;
    localparam logic [DATA_W:0] LIMIT = (DATA_W+1)'(TRUNC_LIMIT) << FRAC_BITS;

    logic [CORR_W-1:0] w_corr_tab [CORR_SIZE];

    for (genvar g = 0; g < CORR_SIZE; g++) begin : g_corr
        localparam logic [DATA_W-1:0] ENTRY = f_corr_entry(g, FRAC_BITS, CORR_TABLE_BITS);
        assign w_corr_tab[g] = ENTRY[CORR_W-1:0];
    end

    logic signed [DATA_W-1:0] w_hi;
    logic signed [DATA_W:0]   w_diff;
    logic [DATA_W:0]          w_abs;
    logic [DATA_W:0]          w_idx_full;
    logic [IDX_W-1:0]         w_idx;
    logic signed [DATA_W:0]   w_sum;

    always_comb begin
        w_hi       = (i_a > i_b) ? i_a : i_b;
        w_diff     = (DATA_W+1)'(i_a) - (DATA_W+1)'(i_b);
        w_abs      = w_diff[DATA_W] ? 33'(-w_diff) : 33'(w_diff);
        w_idx_full = (SH >= 0) ? (w_abs >> SH_R) : (w_abs << SH_L);
        // the index is used only when the difference is within the limit, so it stays in the table
        w_idx      = w_idx_full[IDX_W-1:0];
        w_sum      = (DATA_W+1)'(w_hi)
                   + $signed({{(DATA_W+1-CORR_W){1'b0}}, w_corr_tab[w_idx]});
        if (i_a == LOG_NEG_INF) begin
            o_sum = i_b;
        end else if (i_b == LOG_NEG_INF) begin
            o_sum = i_a;
        end else if (w_abs > LIMIT) begin
            o_sum = w_hi;
        end else if (w_sum > (DATA_W+1)'(LOG_MAX)) begin
            o_sum = LOG_MAX;
        end else begin
            o_sum = w_sum[DATA_W-1:0];
        end
    end

endmodule
